### rtl/core/ief_pkg.sv
package ief_pkg;

    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int INDEX_BITS_DEF = 8;

    localparam int W_BITS        = 12;
    localparam int H_BITS        = 13;
    localparam int ROW_BITS      = 12;
    localparam int OUT_BITS      = 8;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 13;

    localparam int MIN_WIDTH     = 4;
    localparam int MIN_HEIGHT    = 2;
    localparam int MAX_HEIGHT    = 4096;
    localparam int RESET_WIDTH   = 640;
    localparam int RESET_HEIGHT  = 480;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT = 2'd1;

    // item kinds
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    // copies owed after an edge start (three pixels) and after a pair hit
    localparam logic [1:0] COPY_RUN = 2'd2;
    localparam logic [1:0] PAIR_RUN = 2'd1;

    typedef enum logic [1:0] {
        SCAN_NORMAL,
        SCAN_COPY,
        SCAN_PAIR
    } t_scan_mode;

    // per-push control carried from the counter stage to the scan stage
    typedef struct packed {
        logic emit;
        logic border;
        logic top;
        logic bottom;
        logic lt2;
        logic lt3;
        logic last;
        logic clear;
    } t_emit_info;

endpackage

### rtl/core/ief_ctrl.sv
module ief_ctrl #(
    parameter int MAX_WIDTH  = ief_pkg::MAX_WIDTH_DEF,
    parameter int INDEX_BITS = ief_pkg::INDEX_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [ief_pkg::CFG_IDX_BITS-1:0]       i_cfg_index,
    input  logic [ief_pkg::CFG_DATA_BITS-1:0]      i_cfg_data,
    input  logic                                   i_accept,
    input  logic                                   i_kind,
    input  logic [INDEX_BITS-1:0]                  i_pixel_index,
    output logic                                   o_push_valid,
    output logic [$clog2(MAX_WIDTH)-1:0]           o_push_x,
    output logic [INDEX_BITS-1:0]                  o_push_pix,
    output ief_pkg::t_emit_info                    o_push_info,
    output logic                                   o_restart
);
    import ief_pkg::*;

    localparam int COL_BITS  = $clog2(MAX_WIDTH);
    localparam int PEND_BITS = W_BITS + 1;
    localparam logic [W_BITS-1:0] RESET_W =
        W_BITS'((RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH);

    logic [W_BITS-1:0]    r_w;
    logic [H_BITS-1:0]    r_h;
    logic [ROW_BITS-1:0]  r_in_row, n_in_row;
    logic [COL_BITS-1:0]  r_in_col, n_in_col;
    logic [ROW_BITS-1:0]  r_out_row, n_out_row;
    logic [COL_BITS-1:0]  r_out_col, n_out_col;
    logic [PEND_BITS-1:0] r_pending, n_pending;

    logic [PEND_BITS-1:0] lag;
    logic [PEND_BITS-1:0] pend_eff;
    logic [PEND_BITS-1:0] drain_sum;
    logic [W_BITS-1:0]    in_c, out_c;
    logic [H_BITS-1:0]    in_y, out_y;
    logic                 at_start, flush, pix_emit, drain_emit;
    logic                 in_row_end, out_row_end, in_frame_end, out_frame_end;
    logic [W_BITS-1:0]    wd_v;
    logic [H_BITS-1:0]    ht_v;

    always_comb begin
        lag        = {1'b0, r_w} + PEND_BITS'(2);
        in_c       = W_BITS'(r_in_col);
        out_c      = W_BITS'(r_out_col);
        in_y       = {1'b0, r_in_row};
        out_y      = {1'b0, r_out_row};
        at_start   = (r_in_row == '0) && (r_in_col == '0);
        flush      = (i_kind == KIND_PIXEL) && at_start && (r_pending != '0)
                     && (r_pending < lag);
        pend_eff   = flush ? '0 : r_pending;
        pix_emit   = (i_kind == KIND_PIXEL) && (pend_eff >= lag);
        drain_emit = (i_kind == KIND_DRAIN) && at_start && (r_pending != '0);

        in_row_end    = (in_c == r_w - W_BITS'(1));
        out_row_end   = (out_c == r_w - W_BITS'(1));
        in_frame_end  = (in_y == r_h - H_BITS'(1));
        out_frame_end = (out_y == r_h - H_BITS'(1));

        // drain pushes a phantom pixel two columns past the output position
        drain_sum = {1'b0, out_c} + PEND_BITS'(2);
        if (drain_sum >= {1'b0, r_w}) begin
            drain_sum = drain_sum - {1'b0, r_w};
        end
    end

    always_comb begin
        o_push_valid       = (i_kind == KIND_PIXEL) || drain_emit;
        o_push_x           = (i_kind == KIND_PIXEL) ? r_in_col : COL_BITS'(drain_sum);
        o_push_pix         = (i_kind == KIND_PIXEL) ? i_pixel_index : '0;
        o_push_info.emit   = pix_emit || drain_emit;
        o_push_info.border = (out_c == '0) || (out_c >= r_w - W_BITS'(1));
        o_push_info.top    = (r_out_row == '0);
        o_push_info.bottom = out_frame_end;
        o_push_info.lt2    = (out_c < r_w - W_BITS'(2));
        o_push_info.lt3    = (out_c < r_w - W_BITS'(3));
        o_push_info.last   = out_frame_end && out_row_end;
        o_push_info.clear  = flush;
        o_restart          = i_cfg_we && ((i_cfg_index == CFG_FRAME_WIDTH)
                                          || (i_cfg_index == CFG_FRAME_HEIGHT));
    end

    always_comb begin
        n_in_row  = r_in_row;
        n_in_col  = r_in_col;
        n_out_row = r_out_row;
        n_out_col = r_out_col;
        n_pending = r_pending;
        if (flush) begin
            n_out_row = '0;
            n_out_col = '0;
        end
        if (pix_emit || drain_emit) begin
            if (out_row_end) begin
                n_out_col = '0;
                n_out_row = out_frame_end ? '0 : r_out_row + ROW_BITS'(1);
            end else begin
                n_out_col = r_out_col + COL_BITS'(1);
            end
        end
        if (i_kind == KIND_PIXEL) begin
            if (!pix_emit) begin
                n_pending = pend_eff + PEND_BITS'(1);
            end
            if (in_row_end) begin
                n_in_col = '0;
                n_in_row = in_frame_end ? '0 : r_in_row + ROW_BITS'(1);
            end else begin
                n_in_col = r_in_col + COL_BITS'(1);
            end
        end else if (drain_emit) begin
            n_pending = r_pending - PEND_BITS'(1);
        end
    end

    assign wd_v = i_cfg_data[W_BITS-1:0];
    assign ht_v = i_cfg_data[H_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w       <= RESET_W;
            r_h       <= H_BITS'(RESET_HEIGHT);
            r_in_row  <= '0;
            r_in_col  <= '0;
            r_out_row <= '0;
            r_out_col <= '0;
            r_pending <= '0;
        end else if (o_restart) begin
            if (i_cfg_index == CFG_FRAME_WIDTH) begin
                if (wd_v < W_BITS'(MIN_WIDTH)) begin
                    r_w <= W_BITS'(MIN_WIDTH);
                end else if (32'(wd_v) > MAX_WIDTH) begin
                    r_w <= W_BITS'(MAX_WIDTH);
                end else begin
                    r_w <= wd_v;
                end
            end else begin
                if (ht_v < H_BITS'(MIN_HEIGHT)) begin
                    r_h <= H_BITS'(MIN_HEIGHT);
                end else if (ht_v > H_BITS'(MAX_HEIGHT)) begin
                    r_h <= H_BITS'(MAX_HEIGHT);
                end else begin
                    r_h <= ht_v;
                end
            end
            r_in_row  <= '0;
            r_in_col  <= '0;
            r_out_row <= '0;
            r_out_col <= '0;
            r_pending <= '0;
        end else if (i_accept) begin
            r_in_row  <= n_in_row;
            r_in_col  <= n_in_col;
            r_out_row <= n_out_row;
            r_out_col <= n_out_col;
            r_pending <= n_pending;
        end
    end

    a_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (W_BITS'(r_in_col) < r_w) && (W_BITS'(r_out_col) < r_w))
        else $error("column counter past the row end");

    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= ({1'b0, r_w} + PEND_BITS'(2)))
        else $error("owed results exceed the pipeline lag");

endmodule

### rtl/core/ief_line_store.sv
module ief_line_store #(
    parameter int MAX_WIDTH  = ief_pkg::MAX_WIDTH_DEF,
    parameter int INDEX_BITS = ief_pkg::INDEX_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_adv,
    input  logic                             i_push_req,
    input  logic [$clog2(MAX_WIDTH)-1:0]     i_push_x,
    input  logic [INDEX_BITS-1:0]            i_push_pix,
    input  ief_pkg::t_emit_info              i_push_info,
    input  logic                             i_fire,
    output logic                             o_b_valid,
    output ief_pkg::t_emit_info              o_b_info,
    output logic [2:0][INDEX_BITS-1:0]       o_win_u,
    output logic [2:0][INDEX_BITS-1:0]       o_win_i,
    output logic [2:0][INDEX_BITS-1:0]       o_win_d
);
    import ief_pkg::*;

    localparam int COL_BITS = $clog2(MAX_WIDTH);

    // one slot per column: older and newer of the last two pixels at that column
    logic [INDEX_BITS-1:0] mem_above [MAX_WIDTH];
    logic [INDEX_BITS-1:0] mem_mid   [MAX_WIDTH];

    logic                  r_b_valid;
    logic [COL_BITS-1:0]   r_b_x;
    logic [INDEX_BITS-1:0] r_b_pix;
    t_emit_info            r_b_info;
    logic [INDEX_BITS-1:0] r_rd_above, r_rd_mid;
    logic                  r_fwd;
    logic [INDEX_BITS-1:0] r_fwd_above, r_fwd_mid;
    logic [2:0][INDEX_BITS-1:0] r_win_u, r_win_i, r_win_d;
    logic [INDEX_BITS-1:0] eff_above, eff_mid;
    logic                  load;

    assign load      = i_adv && i_push_req;
    // the write of the previous push lands on the edge of this read
    assign eff_above = r_fwd ? r_fwd_above : r_rd_above;
    assign eff_mid   = r_fwd ? r_fwd_mid : r_rd_mid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (i_adv) begin
            r_b_valid <= i_push_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_b_x       <= i_push_x;
            r_b_pix     <= i_push_pix;
            r_b_info    <= i_push_info;
            r_fwd       <= i_fire && (r_b_x == i_push_x);
            r_fwd_above <= eff_mid;
            r_fwd_mid   <= r_b_pix;
        end
        if (i_fire) begin
            r_win_u <= {r_win_u[1:0], eff_above};
            r_win_i <= {r_win_i[1:0], eff_mid};
            r_win_d <= {r_win_d[1:0], r_b_pix};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            mem_above[r_b_x] <= eff_mid;
            mem_mid[r_b_x]   <= r_b_pix;
        end
        if (load) begin
            r_rd_above <= mem_above[i_push_x];
            r_rd_mid   <= mem_mid[i_push_x];
        end
    end

    assign o_b_valid = r_b_valid;
    assign o_b_info  = r_b_info;
    assign o_win_u   = r_win_u;
    assign o_win_i   = r_win_i;
    assign o_win_d   = r_win_d;

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid && !i_fire |=> r_b_valid && $stable(r_b_x) && $stable(r_b_pix))
        else $error("stalled push changed before completing");

    a_no_load_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid && !i_fire |-> !load)
        else $error("new push loaded over a stalled one");

endmodule

### rtl/core/ief_scan.sv
module ief_scan #(
    parameter int INDEX_BITS = ief_pkg::INDEX_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_restart,
    input  logic                             i_fire,
    input  ief_pkg::t_emit_info              i_info,
    input  logic [2:0][INDEX_BITS-1:0]       i_win_u,
    input  logic [2:0][INDEX_BITS-1:0]       i_win_i,
    input  logic [2:0][INDEX_BITS-1:0]       i_win_d,
    input  logic                             i_out_ready,
    output logic                             o_out_free,
    output logic                             o_out_valid,
    output logic [ief_pkg::OUT_BITS-1:0]     o_out_index,
    output logic                             o_raw_zero,
    output logic                             o_frame_last
);
    import ief_pkg::*;

    t_scan_mode r_mode, n_mode, cur_mode;
    logic [1:0] r_copies, n_copies, cur_copies, dec_copies;

    logic                  r_out_valid;
    logic [OUT_BITS-1:0]   r_out_index;
    logic                  r_raw_zero;
    logic                  r_frame_last;

    logic [INDEX_BITS-1:0] im, i0, ip, um, u0, up, dm, d0, dp;
    logic                  edge_next, pair_hit, left_hit, sel;

    // window slot 0 is column c+1, slot 2 is column c-1
    always_comb begin
        im = i_win_i[2];
        i0 = i_win_i[1];
        ip = i_win_i[0];
        um = i_info.top ? im : i_win_u[2];
        u0 = i_info.top ? i0 : i_win_u[1];
        up = i_info.top ? ip : i_win_u[0];
        dm = i_info.bottom ? im : i_win_d[2];
        d0 = i_info.bottom ? i0 : i_win_d[1];
        dp = i_info.bottom ? ip : i_win_d[0];
        edge_next = (ip != i0) || (up != i0) || (dp != i0);
        pair_hit  = i_info.lt2 && ((u0 != i0) || (d0 != i0));
        left_hit  = (im != i0) || (um != i0) || (dm != i0);
        cur_mode   = i_info.clear ? SCAN_NORMAL : r_mode;
        cur_copies = i_info.clear ? 2'd0 : r_copies;
        dec_copies = (cur_copies != 2'd0) ? cur_copies - 2'd1 : 2'd0;
    end

    // next scan state
    always_comb begin
        n_mode   = cur_mode;
        n_copies = cur_copies;
        if (i_info.emit) begin
            if (i_info.border) begin
                n_mode   = SCAN_NORMAL;
                n_copies = 2'd0;
            end else begin
                unique case (cur_mode)
                    SCAN_COPY: begin
                        n_copies = dec_copies;
                        n_mode   = (dec_copies == 2'd0) ? SCAN_PAIR : SCAN_COPY;
                    end
                    SCAN_PAIR: begin
                        if (pair_hit) begin
                            n_mode   = SCAN_COPY;
                            n_copies = PAIR_RUN;
                        end else if (left_hit || !(edge_next && i_info.lt3)) begin
                            n_mode = SCAN_NORMAL;
                        end else begin
                            n_mode   = SCAN_COPY;
                            n_copies = COPY_RUN;
                        end
                    end
                    default: begin
                        if (edge_next && i_info.lt3) begin
                            n_mode   = SCAN_COPY;
                            n_copies = COPY_RUN;
                        end else begin
                            n_mode = SCAN_NORMAL;
                        end
                    end
                endcase
            end
        end
    end

    // whether the center pixel is copied out
    always_comb begin
        if (i_info.border) begin
            sel = 1'b0;
        end else begin
            unique case (cur_mode)
                SCAN_COPY: sel = 1'b1;
                SCAN_PAIR: sel = pair_hit || left_hit || edge_next;
                default:   sel = edge_next;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= SCAN_NORMAL;
            r_copies    <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_restart) begin
                r_mode   <= SCAN_NORMAL;
                r_copies <= 2'd0;
            end else if (i_fire) begin
                r_mode   <= n_mode;
                r_copies <= n_copies;
            end
            if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_fire && i_info.emit) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && i_info.emit) begin
            r_out_index  <= sel ? OUT_BITS'(i0) : '0;
            r_raw_zero   <= i_info.border;
            r_frame_last <= i_info.last;
        end
    end

    assign o_out_free   = !r_out_valid || i_out_ready;
    assign o_out_valid  = r_out_valid;
    assign o_out_index  = r_out_index;
    assign o_raw_zero   = r_raw_zero;
    assign o_frame_last = r_frame_last;

    a_copy_owes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == SCAN_COPY) |-> (r_copies != 2'd0))
        else $error("copy mode with nothing left to copy");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !(i_fire && i_info.emit))
        else $error("result register overwritten before transfer");

endmodule

### rtl/core/indexed_edge_filter_core.sv
// Edge filter for a raster stream of palette-index pixels, one item per clock in both
// directions when neither side stalls. A pixel item first pays into a fill of
// frame_width+2 items and after that releases one result, so the output trails the
// input by frame_width+2 positions; drain items sent once a frame is fully in flush
// the tail, one result each, and are dropped otherwise. Each pushed item passes two
// registers: at the input transfer the counter stage picks its column and reads both
// line-store memories into the push register, then when the push fires the scan stage
// updates the column slot, slides the 3x3 window and runs the copy/pair state machine
// into the result register. A stalled result register holds back the scan stage and
// with it the input; the line stores are not cleared after reset, and a write to
// frame_width or frame_height restarts the frame counters and the scan state.
module indexed_edge_filter_core #(
    parameter int MAX_WIDTH  = ief_pkg::MAX_WIDTH_DEF,
    parameter int INDEX_BITS = ief_pkg::INDEX_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [ief_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [ief_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_kind,
    input  logic [INDEX_BITS-1:0]              i_pixel_index,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [ief_pkg::OUT_BITS-1:0]       o_out_index,
    output logic                               o_raw_zero,
    output logic                               o_frame_last
);
    import ief_pkg::*;

    localparam int COL_BITS = $clog2(MAX_WIDTH);

    logic                       accept;
    logic                       push_valid;
    logic [COL_BITS-1:0]        push_x;
    logic [INDEX_BITS-1:0]      push_pix;
    t_emit_info                 push_info;
    logic                       restart;
    logic                       b_valid;
    t_emit_info                 b_info;
    logic                       fire;
    logic                       out_free;
    logic [2:0][INDEX_BITS-1:0] win_u, win_i, win_d;

    assign fire       = b_valid && (!b_info.emit || out_free);
    assign o_in_ready = !b_valid || fire;
    assign accept     = i_in_valid && o_in_ready;

    ief_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .INDEX_BITS (INDEX_BITS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_accept      (accept),
        .i_kind        (i_kind),
        .i_pixel_index (i_pixel_index),
        .o_push_valid  (push_valid),
        .o_push_x      (push_x),
        .o_push_pix    (push_pix),
        .o_push_info   (push_info),
        .o_restart     (restart)
    );

    ief_line_store #(
        .MAX_WIDTH  (MAX_WIDTH),
        .INDEX_BITS (INDEX_BITS)
    ) u_line_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (o_in_ready),
        .i_push_req  (accept && push_valid),
        .i_push_x    (push_x),
        .i_push_pix  (push_pix),
        .i_push_info (push_info),
        .i_fire      (fire),
        .o_b_valid   (b_valid),
        .o_b_info    (b_info),
        .o_win_u     (win_u),
        .o_win_i     (win_i),
        .o_win_d     (win_d)
    );

    ief_scan #(
        .INDEX_BITS (INDEX_BITS)
    ) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_restart    (restart),
        .i_fire       (fire),
        .i_info       (b_info),
        .i_win_u      (win_u),
        .i_win_i      (win_i),
        .i_win_d      (win_d),
        .i_out_ready  (i_out_ready),
        .o_out_free   (out_free),
        .o_out_valid  (o_out_valid),
        .o_out_index  (o_out_index),
        .o_raw_zero   (o_raw_zero),
        .o_frame_last (o_frame_last)
    );

endmodule

### sim/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ief_pkg::*;

    localparam int PIX_BITS = INDEX_BITS_DEF;
    localparam int unsigned LINE_DEPTH = MAX_WIDTH_DEF;
    localparam int unsigned RANDOM_ITEMS = 1600;
    localparam int unsigned SETTLE_CYCLES = 6;
    localparam int unsigned QUIET_LIMIT = 1000;
    localparam int unsigned REPORT_CAP = 100;
    localparam int unsigned RUN_AFTER_EDGE = 2;
    localparam int unsigned RUN_AFTER_PAIR = 1;

    // indexes the port accepts but that map to no register
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_B = 2'd3;

    typedef logic [PIX_BITS-1:0] t_pix;

    typedef struct packed {
        logic kind;
        t_pix pix;
    } t_feed_item;

    typedef struct packed {
        logic [OUT_BITS-1:0] idx;
        logic                raw;
        logic                is_last;
    } t_edge_px;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;
    logic                     in_valid = 1'b0;
    logic                     in_kind = KIND_PIXEL;
    t_pix                     in_pix = '0;
    logic                     out_ready = 1'b0;
    logic                     o_in_ready;
    logic                     o_out_valid;
    logic [OUT_BITS-1:0]      o_out_index;
    logic                     o_raw_zero;
    logic                     o_frame_last;

    t_feed_item  feed_q[$];
    t_edge_px    edge_expect[$];
    int unsigned fail_count = 0;
    int unsigned quiet_cycles = 0;
    int unsigned gap_pct = 0;
    int unsigned stall_pct = 0;
    bit          calm = 1'b0;
    bit          noise_on = 1'b1;

    // pixel content generator
    t_pix        palette[4];
    int unsigned pal_n = 0;
    t_pix        last_pix = '0;

    // predictor state
    t_pix        row_old_mem[LINE_DEPTH];
    t_pix        row_new_mem[LINE_DEPTH];
    logic [11:0] reg_width;
    logic [12:0] reg_height;
    int unsigned cols, rows;
    int unsigned in_row, in_col, out_row, out_col, owed;
    t_scan_mode  scan_st;
    int unsigned copies_owed;
    t_pix        spill_near, spill_mid, spill_far;

    indexed_edge_filter_core u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_ready    (o_in_ready),
        .i_kind        (in_kind),
        .i_pixel_index (in_pix),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (out_ready),
        .o_out_index   (o_out_index),
        .o_raw_zero    (o_raw_zero),
        .o_frame_last  (o_frame_last)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    task automatic shift_in(int unsigned x, t_pix v);
        spill_far = spill_mid;
        spill_mid = spill_near;
        spill_near = row_old_mem[x];
        row_old_mem[x] = row_new_mem[x];
        row_new_mem[x] = v;
    endtask

    task automatic emit_px(output t_edge_px r);
        int unsigned y, c;
        t_pix im, i0, ip, um, u0, up, dm, d0, dp;
        bit done;
        y = out_row;
        c = out_col;
        r = '0;
        if (c == 0 || c >= cols - 1) begin
            r.raw = 1'b1;
            scan_st = SCAN_NORMAL;
            copies_owed = 0;
        end else begin
            im = row_old_mem[c - 1];
            i0 = row_old_mem[c];
            ip = row_old_mem[c + 1];
            um = spill_far;
            u0 = spill_mid;
            up = spill_near;
            dm = row_new_mem[c - 1];
            d0 = row_new_mem[c];
            dp = row_new_mem[c + 1];
            done = 1'b0;
            // top and bottom rows mirror the current row
            if (y == 0) begin
                um = im; u0 = i0; up = ip;
            end
            if (y == rows - 1) begin
                dm = im; d0 = i0; dp = ip;
            end
            if (scan_st == SCAN_COPY) begin
                r.idx = i0;
                if (copies_owed > 0) copies_owed--;
                if (copies_owed == 0) scan_st = SCAN_PAIR;
                done = 1'b1;
            end else if (scan_st == SCAN_PAIR) begin
                if (c < cols - 2 && (i0 != u0 || i0 != d0)) begin
                    r.idx = i0;
                    copies_owed = RUN_AFTER_PAIR;
                    scan_st = SCAN_COPY;
                    done = 1'b1;
                end else begin
                    scan_st = SCAN_NORMAL;
                    if (im != i0 || um != i0 || dm != i0) begin
                        r.idx = i0;
                        done = 1'b1;
                    end
                end
            end
            if (!done) begin
                scan_st = SCAN_NORMAL;
                if (ip != i0 || i0 != up || i0 != dp) begin
                    r.idx = i0;
                    if (c < cols - 3) begin
                        copies_owed = RUN_AFTER_EDGE;
                        scan_st = SCAN_COPY;
                    end
                end
            end
        end
        r.is_last = (y == rows - 1 && c == cols - 1);
        c++;
        if (c >= cols) begin
            c = 0;
            y++;
            if (y >= rows) y = 0;
        end
        out_col = c;
        out_row = y;
    endtask

    task automatic edge_predict(logic kind, t_pix pix);
        t_edge_px r;
        int unsigned lag, x;
        bit at_start;
        lag = cols + 2;
        at_start = (in_row == 0 && in_col == 0);
        if (kind == KIND_PIXEL) begin
            x = in_col;
            // new frame while a drained one still owes results: drop them
            if (at_start && owed > 0 && owed < lag) begin
                owed = 0;
                out_row = 0;
                out_col = 0;
                scan_st = SCAN_NORMAL;
                copies_owed = 0;
            end
            if (owed >= lag) begin
                emit_px(r);
                edge_expect.push_back(r);
            end else begin
                owed++;
            end
            shift_in(x, pix);
            in_col++;
            if (in_col >= cols) begin
                in_col = 0;
                in_row++;
                if (in_row >= rows) in_row = 0;
            end
        end else if (at_start && owed != 0) begin
            x = (out_col + 2) % cols;
            emit_px(r);
            edge_expect.push_back(r);
            shift_in(x, '0);
            owed--;
        end
    endtask

    task automatic cfg_apply(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        if (idx == CFG_FRAME_WIDTH) reg_width = data[11:0];
        else if (idx == CFG_FRAME_HEIGHT) reg_height = data;
        else return;
        cols = (reg_width < MIN_WIDTH) ? MIN_WIDTH :
               (reg_width > LINE_DEPTH) ? LINE_DEPTH : reg_width;
        rows = (reg_height < MIN_HEIGHT) ? MIN_HEIGHT :
               (reg_height > MAX_HEIGHT) ? MAX_HEIGHT : reg_height;
        in_row = 0;
        in_col = 0;
        out_row = 0;
        out_col = 0;
        owed = 0;
        scan_st = SCAN_NORMAL;
        copies_owed = 0;
    endtask

    // ---------------------------------------------------------------- driver

    always @(posedge clk) begin : driver
        t_feed_item item;
        int unsigned send_gap;
        if (!rst_n) begin
            in_valid <= 1'b0;
            send_gap = 0;
        end else if (!in_valid || o_in_ready) begin
            if (send_gap != 0) begin
                send_gap--;
                in_valid <= 1'b0;
            end else if (feed_q.size() != 0) begin
                item = feed_q.pop_front();
                in_valid <= 1'b1;
                in_kind <= item.kind;
                in_pix <= item.pix;
                if (!calm && $urandom_range(0, 99) < gap_pct) send_gap = $urandom_range(1, 14);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- monitor

    task automatic report_diff(string field, logic [7:0] want, logic [7:0] got);
        fail_count++;
        if (fail_count <= REPORT_CAP)
            $display("%0t ns: %s expected %0d got %0d", $time, field, want, got);
    endtask

    always @(posedge clk) begin : monitor
        t_edge_px got, want;
        int unsigned stall_left;
        if (!rst_n) begin
            stall_left = 0;
        end else begin
            if (o_out_valid && out_ready) begin
                got = '{idx: o_out_index, raw: o_raw_zero, is_last: o_frame_last};
                if (edge_expect.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_CAP)
                        $display("%0t ns: result with none pending, expected nothing got %0d/%0b/%0b",
                                 $time, got.idx, got.raw, got.is_last);
                end else begin
                    want = edge_expect.pop_front();
                    if (got.idx !== want.idx) report_diff("out_index", want.idx, got.idx);
                    if (got.raw !== want.raw)
                        report_diff("raw_zero", 8'(want.raw), 8'(got.raw));
                    if (got.is_last !== want.is_last)
                        report_diff("frame_last", 8'(want.is_last), 8'(got.is_last));
                end
            end
            // results of this transfer can only show up on later edges
            if (in_valid && o_in_ready) edge_predict(in_kind, in_pix);
            if (stall_left != 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
                stall_left = $urandom_range(0, 13);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready) || cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------- stimulus

    task automatic queue_item(logic kind, t_pix pix);
        feed_q.push_back('{kind: kind, pix: pix});
    endtask

    task automatic settle();
        do @(negedge clk); while (feed_q.size() != 0 || in_valid || edge_expect.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        settle();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        cfg_apply(idx, data);
    endtask

    task automatic pick_palette();
        foreach (palette[k]) palette[k] = t_pix'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < 15) begin
            pal_n = 0;
        end else begin
            pal_n = $urandom_range(2, 4);
        end
    endtask

    // flat runs keep most columns quiet so the scan modes get exercised
    task automatic queue_frame(int unsigned count);
        for (int unsigned n = 0; n < count; n++) begin
            if (noise_on && n != 0 && $urandom_range(0, 39) == 0)
                queue_item(KIND_DRAIN, t_pix'($urandom_range(0, 255)));
            if (pal_n == 0) last_pix = t_pix'($urandom_range(0, 255));
            else if ($urandom_range(0, 99) >= 55) last_pix = palette[$urandom_range(0, pal_n - 1)];
            queue_item(KIND_PIXEL, last_pix);
        end
    endtask

    task automatic random_phase(output int unsigned count);
        int unsigned wdata, hdata, frames, cut, n, pick;
        count = 0;
        if (!calm) begin
            pick = $urandom_range(0, 3);
            gap_pct = (pick == 0) ? 0 : (pick == 1) ? 3 : (pick == 2) ? 15 : 40;
            pick = $urandom_range(0, 3);
            stall_pct = (pick == 0) ? 0 : (pick == 1) ? 3 : (pick == 2) ? 15 : 40;
        end
        pick = $urandom_range(0, 99);
        if (pick < 5) wdata = $urandom_range(0, 3);
        else if (pick < 70) wdata = $urandom_range(4, 12);
        else if (pick < 92) wdata = $urandom_range(13, 40);
        else wdata = $urandom_range(41, 120);
        // bit 12 of the data word is not part of the width
        if ($urandom_range(0, 7) == 0) wdata += 4096;
        pick = $urandom_range(0, 99);
        if (pick < 8) hdata = $urandom_range(0, 1);
        else if (pick < 85) hdata = $urandom_range(2, 4);
        else hdata = $urandom_range(5, 8);
        write_reg(CFG_FRAME_WIDTH, CFG_DATA_BITS'(wdata));
        write_reg(CFG_FRAME_HEIGHT, CFG_DATA_BITS'(hdata));
        frames = $urandom_range(1, 4);
        for (int unsigned f = 0; f < frames; f++) begin
            pick_palette();
            cut = cols * rows;
            if (f == frames - 1 && $urandom_range(0, 5) == 0) cut = $urandom_range(1, cut - 1);
            queue_frame(cut);
            count += cut;
            if (cut == cols * rows) begin
                pick = $urandom_range(0, 3);
                if (pick < 2) n = cols + 2;
                else if (pick == 2) n = $urandom_range(1, cols + 1);
                else n = 0;
                count += n;
                if (pick < 2) n += $urandom_range(0, 2);
                repeat (n) queue_item(KIND_DRAIN, t_pix'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 7) == 0)
                write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                          CFG_DATA_BITS'($urandom_range(0, 8191)));
        end
    endtask

    initial begin
        int unsigned done_items, got_items;
        reg_width = 12'(RESET_WIDTH);
        reg_height = 13'(RESET_HEIGHT);
        cols = RESET_WIDTH;
        rows = RESET_HEIGHT;
        in_row = 0;
        in_col = 0;
        out_row = 0;
        out_col = 0;
        owed = 0;
        scan_st = SCAN_NORMAL;
        copies_owed = 0;
        spill_near = '0;
        spill_mid = '0;
        spill_far = '0;
        foreach (row_old_mem[k]) begin
            row_old_mem[k] = '0;
            row_new_mem[k] = '0;
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // nothing owed yet, so this drain is dropped
        queue_item(KIND_DRAIN, 8'hFF);
        write_reg(CFG_FRAME_WIDTH, 13'd4);
        write_reg(CFG_FRAME_HEIGHT, 13'd2);
        queue_item(KIND_PIXEL, 8'h00);
        queue_item(KIND_PIXEL, 8'hFF);
        queue_item(KIND_PIXEL, 8'hFF);
        queue_item(KIND_PIXEL, 8'h00);
        queue_item(KIND_PIXEL, 8'hFF);
        queue_item(KIND_PIXEL, 8'h00);
        queue_item(KIND_PIXEL, 8'h00);
        queue_item(KIND_PIXEL, 8'hFF);
        // partial drain, then a new frame discards the rest
        repeat (3) queue_item(KIND_DRAIN, 8'h00);
        queue_item(KIND_PIXEL, 8'h0F);
        queue_item(KIND_PIXEL, 8'h0F);
        queue_item(KIND_PIXEL, 8'hF0);
        queue_item(KIND_PIXEL, 8'h0F);
        queue_item(KIND_PIXEL, 8'hA5);
        queue_item(KIND_PIXEL, 8'h5A);
        queue_item(KIND_PIXEL, 8'h5A);
        queue_item(KIND_PIXEL, 8'h0F);
        repeat (7) queue_item(KIND_DRAIN, 8'h00);

        // widest line with the shortest frame, both written out of range;
        // only the start of the frame goes in, so mid-frame drains are dropped
        gap_pct = 15;
        stall_pct = 15;
        write_reg(CFG_FRAME_WIDTH, 13'h1FFF);
        write_reg(CFG_FRAME_HEIGHT, 13'h0001);
        pick_palette();
        pal_n = 3;
        queue_frame(48);
        repeat (4) queue_item(KIND_DRAIN, 8'h00);

        // tallest frame on the narrowest line; spare indexes must not restart it
        write_reg(CFG_FRAME_WIDTH, 13'h0000);
        write_reg(CFG_FRAME_HEIGHT, 13'h1FFF);
        queue_frame(40);
        write_reg(CFG_SPARE_A, 13'h1FFF);
        queue_frame(40);
        write_reg(CFG_SPARE_B, 13'h0000);
        queue_frame(40);

        done_items = 0;
        while (done_items < RANDOM_ITEMS) begin
            random_phase(got_items);
            done_items += got_items;
        end

        calm = 1'b1;
        noise_on = 1'b0;
        random_phase(got_items);

        settle();
        repeat (10) @(posedge clk);
        if (fail_count == 0 && edge_expect.size() == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end

endmodule
